@@ rtl/core/mle_pkg.sv @@
// Shared constants and control/status types for the line-envelope DP block.
// Used by every module of the block; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mle_pkg;

   localparam int MAX_LINES_DEF = 1024;
   localparam int SLOPE_W       = 32;
   localparam int X_W           = 32;
   localparam int COST_W        = 63;
   localparam int PROD_W        = SLOPE_W + X_W;
   localparam int ACC_W         = 96;

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // latch the new item
      logic cost_zero;  // start item: cost begins at zero
      logic rd_en;
      logic scan;       // read belongs to the minimum scan
      logic wr_en;
      logic wr_new;     // write the new line, else the last read entry
      logic ld_a;
      logic ld_b;
      logic ld_c;
      logic src_a_new;
      logic src_b_new;
      logic src_c_new;
      logic mu_start;
      logic out_load;
      logic out_full;
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic found;      // a stored slope at or below the new one was seen
      logic eq;         // that slope equals the new one
      logic eq_le;      // its intercept is at or below the new cost
      logic mu_done;
      logic mu_useless;
   } dp_status_type;

endpackage
`default_nettype wire

@@ rtl/core/mle_mu.sv @@
// Middle-line test: is line b off the lower envelope of lines a and c?
// Exact cross-multiplication, done in steps with one 32x32 multiplier.
// Depends on mle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mle_mu (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [mle_pkg::SLOPE_W-1:0]       a_s,
   input  wire logic [mle_pkg::COST_W-1:0]        a_c,
   input  wire logic [mle_pkg::SLOPE_W-1:0]       b_s,
   input  wire logic [mle_pkg::COST_W-1:0]        b_c,
   input  wire logic [mle_pkg::SLOPE_W-1:0]       c_s,
   input  wire logic [mle_pkg::COST_W-1:0]        c_c,
   output logic                                   done,
   output logic                                   useless
);

   localparam logic [2:0] STEP_DIFF  = 3'd0;
   localparam logic [2:0] STEP_L_LO  = 3'd1;
   localparam logic [2:0] STEP_L_HI  = 3'd2;
   localparam logic [2:0] STEP_R_LO  = 3'd3;
   localparam logic [2:0] STEP_R_HI  = 3'd4;
   localparam logic [2:0] STEP_R_ACC = 3'd5;
   localparam logic [2:0] STEP_CMP   = 3'd6;

   logic                          busy_ff, busy_in;
   logic [2:0]                    step_ff, step_in;
   logic                          done_ff, done_in;
   logic                          useless_ff, useless_in;
   logic [mle_pkg::COST_W-1:0]    dl_ff, dl_in, dr_ff, dr_in;
   logic                          nl_ff, nl_in, nr_ff, nr_in;
   logic [mle_pkg::SLOPE_W-1:0]   f1_ff, f1_in, f2_ff, f2_in;
   logic [63:0]                   mul_ff, mul_in;
   logic [mle_pkg::ACC_W-1:0]     acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic [31:0]                   op_a, op_b;
   logic                          z1, z2, n1, n2, cmp_res;

   always_comb begin
      op_a = dl_ff[31:0];
      op_b = f1_ff;
      case (step_ff)
         STEP_L_LO: begin
            op_a = dl_ff[31:0];
            op_b = f1_ff;
         end
         STEP_L_HI: begin
            op_a = {1'b0, dl_ff[62:32]};
            op_b = f1_ff;
         end
         STEP_R_LO: begin
            op_a = dr_ff[31:0];
            op_b = f2_ff;
         end
         STEP_R_HI: begin
            op_a = {1'b0, dr_ff[62:32]};
            op_b = f2_ff;
         end
         default: begin
            op_a = dl_ff[31:0];
            op_b = f1_ff;
         end
      endcase
   end

   always_comb begin
      z1 = (acc1_ff == '0);
      z2 = (acc2_ff == '0);
      // a zero product carries no sign
      n1 = nl_ff & ~z1;
      n2 = nr_ff & ~z2;
      if (n1 != n2)
         cmp_res = n1;
      else if (!n1)
         cmp_res = (acc1_ff <= acc2_ff);
      else
         cmp_res = (acc2_ff <= acc1_ff);
   end

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      done_in    = 1'b0;
      useless_in = useless_ff;
      dl_in      = dl_ff;
      dr_in      = dr_ff;
      nl_in      = nl_ff;
      nr_in      = nr_ff;
      f1_in      = f1_ff;
      f2_in      = f2_ff;
      mul_in     = op_a * op_b;
      acc1_in    = acc1_ff;
      acc2_in    = acc2_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_DIFF;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         case (step_ff)
            STEP_DIFF: begin
               nl_in = (c_c < a_c);
               dl_in = (c_c < a_c) ? (a_c - c_c) : (c_c - a_c);
               nr_in = (b_c < a_c);
               dr_in = (b_c < a_c) ? (a_c - b_c) : (b_c - a_c);
               f1_in = a_s - b_s;
               f2_in = a_s - c_s;
            end
            STEP_L_HI:  acc1_in = {32'd0, mul_ff};
            STEP_R_LO:  acc1_in = acc1_ff + {mul_ff, 32'd0};
            STEP_R_HI:  acc2_in = {32'd0, mul_ff};
            STEP_R_ACC: acc2_in = acc2_ff + {mul_ff, 32'd0};
            STEP_CMP: begin
               useless_in = cmp_res;
               done_in    = 1'b1;
               busy_in    = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_DIFF;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      useless_ff <= useless_in;
      dl_ff      <= dl_in;
      dr_ff      <= dr_in;
      nl_ff      <= nl_in;
      nr_ff      <= nr_in;
      f1_ff      <= f1_in;
      f2_ff      <= f2_in;
      mul_ff     <= mul_in;
      acc1_ff    <= acc1_in;
      acc2_ff    <= acc2_in;
   end

   assign done    = done_ff;
   assign useless = useless_ff;

endmodule
`default_nettype wire

@@ rtl/core/mle_dp.sv @@
// Datapath: line store memories, minimum scan pipeline, test line registers,
// result register. Driven by mle_ctrl; instantiates mle_mu; uses mle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mle_dp #(
   parameter int MAX_LINES = mle_pkg::MAX_LINES_DEF,
   parameter int AW        = $clog2(MAX_LINES)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [mle_pkg::SLOPE_W-1:0]     req_slope,
   input  wire logic [mle_pkg::X_W-1:0]         req_query_x,
   input  wire mle_pkg::ctl_cmd_type            cmd,
   input  wire logic [AW-1:0]                   rd_addr,
   input  wire logic [AW-1:0]                   wr_addr,
   output mle_pkg::dp_status_type               status,
   output logic [AW-1:0]                        p_idx,
   output logic [mle_pkg::COST_W-1:0]           rsp_cost,
   output logic                                 rsp_store_full
);

   logic [mle_pkg::SLOPE_W-1:0] slope_mem [MAX_LINES];
   logic [mle_pkg::COST_W-1:0]  icpt_mem  [MAX_LINES];

   logic [mle_pkg::SLOPE_W-1:0] rd_s_ff;
   logic [mle_pkg::COST_W-1:0]  rd_c_ff;

   logic [mle_pkg::SLOPE_W-1:0] m_ff, m_in;
   logic [mle_pkg::X_W-1:0]     x_ff, x_in;
   logic [mle_pkg::COST_W-1:0]  cost_ff, cost_in;
   logic                        v1_ff, v1_in, v2_ff, v2_in;
   logic [AW-1:0]               idx1_ff, idx1_in;
   logic [mle_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [mle_pkg::COST_W-1:0]  c2_ff, c2_in;
   logic                        found_ff, found_in, eq_ff, eq_in;
   logic [mle_pkg::COST_W-1:0]  eqc_ff, eqc_in;
   logic [AW-1:0]               p_ff, p_in;
   logic [mle_pkg::SLOPE_W-1:0] la_s_ff, la_s_in, lb_s_ff, lb_s_in, lc_s_ff, lc_s_in;
   logic [mle_pkg::COST_W-1:0]  la_c_ff, la_c_in, lb_c_ff, lb_c_in, lc_c_ff, lc_c_in;
   logic [mle_pkg::COST_W-1:0]  rsp_cost_ff, rsp_cost_in;
   logic                        rsp_full_ff, rsp_full_in;
   logic [mle_pkg::PROD_W:0]    sum;
   logic [mle_pkg::COST_W-1:0]  val;
   logic                        mu_done, mu_useless;

   // line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slope_mem[wr_addr] <= cmd.wr_new ? m_ff : rd_s_ff;
         icpt_mem[wr_addr]  <= cmd.wr_new ? cost_ff : rd_c_ff;
      end
      if (cmd.rd_en) begin
         rd_s_ff <= slope_mem[rd_addr];
         rd_c_ff <= icpt_mem[rd_addr];
      end
   end

   always_comb begin
      sum = {1'b0, prod_ff} + {2'b00, c2_ff};
      val = (sum > {2'b00, mle_pkg::COST_MAX}) ? mle_pkg::COST_MAX
                                               : sum[mle_pkg::COST_W-1:0];
   end

   always_comb begin
      m_in        = m_ff;
      x_in        = x_ff;
      cost_in     = cost_ff;
      v1_in       = cmd.rd_en & cmd.scan;
      idx1_in     = rd_addr;
      prod_in     = rd_s_ff * x_ff;
      c2_in       = rd_c_ff;
      v2_in       = v1_ff;
      found_in    = found_ff;
      eq_in       = eq_ff;
      eqc_in      = eqc_ff;
      p_in        = p_ff;
      la_s_in     = la_s_ff;
      la_c_in     = la_c_ff;
      lb_s_in     = lb_s_ff;
      lb_c_in     = lb_c_ff;
      lc_s_in     = lc_s_ff;
      lc_c_in     = lc_c_ff;
      rsp_cost_in = rsp_cost_ff;
      rsp_full_in = rsp_full_ff;
      if (cmd.accept) begin
         m_in     = req_slope;
         x_in     = req_query_x;
         cost_in  = cmd.cost_zero ? '0 : mle_pkg::COST_MAX;
         found_in = 1'b0;
      end else begin
         if (v2_ff && (val < cost_ff))
            cost_in = val;
         // slopes fall along the store: take the first one at or below m
         if (v1_ff && !found_ff && (rd_s_ff <= m_ff)) begin
            found_in = 1'b1;
            p_in     = idx1_ff;
            eq_in    = (rd_s_ff == m_ff);
            eqc_in   = rd_c_ff;
         end
      end
      if (cmd.ld_a) begin
         la_s_in = cmd.src_a_new ? m_ff : rd_s_ff;
         la_c_in = cmd.src_a_new ? cost_ff : rd_c_ff;
      end
      if (cmd.ld_b) begin
         lb_s_in = cmd.src_b_new ? m_ff : rd_s_ff;
         lb_c_in = cmd.src_b_new ? cost_ff : rd_c_ff;
      end
      if (cmd.ld_c) begin
         lc_s_in = cmd.src_c_new ? m_ff : rd_s_ff;
         lc_c_in = cmd.src_c_new ? cost_ff : rd_c_ff;
      end
      if (cmd.out_load) begin
         rsp_cost_in = cost_ff;
         rsp_full_in = cmd.out_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         found_ff <= found_in;
      end
      m_ff        <= m_in;
      x_ff        <= x_in;
      cost_ff     <= cost_in;
      idx1_ff     <= idx1_in;
      prod_ff     <= prod_in;
      c2_ff       <= c2_in;
      eq_ff       <= eq_in;
      eqc_ff      <= eqc_in;
      p_ff        <= p_in;
      la_s_ff     <= la_s_in;
      la_c_ff     <= la_c_in;
      lb_s_ff     <= lb_s_in;
      lb_c_ff     <= lb_c_in;
      lc_s_ff     <= lc_s_in;
      lc_c_ff     <= lc_c_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_full_ff <= rsp_full_in;
   end

   mle_mu u_mu (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mu_start),
      .a_s     (la_s_ff),
      .a_c     (la_c_ff),
      .b_s     (lb_s_ff),
      .b_c     (lb_c_ff),
      .c_s     (lc_s_ff),
      .c_c     (lc_c_ff),
      .done    (mu_done),
      .useless (mu_useless)
   );

   always_comb begin
      status.found      = found_ff;
      status.eq         = eq_ff;
      status.eq_le      = (eqc_ff <= cost_ff);
      status.mu_done    = mu_done;
      status.mu_useless = mu_useless;
   end

   assign p_idx          = p_ff;
   assign rsp_cost       = rsp_cost_ff;
   assign rsp_store_full = rsp_full_ff;

endmodule
`default_nettype wire

@@ rtl/core/mle_ctrl.sv @@
// Controller: sequences scan, envelope tests, store moves and result hand-off.
// Holds the line count and store indices; drives mle_dp. Uses mle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mle_ctrl #(
   parameter int MAX_LINES = mle_pkg::MAX_LINES_DEF,
   parameter int AW        = $clog2(MAX_LINES),
   parameter int IW        = $clog2(MAX_LINES + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_start_req,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire mle_pkg::dp_status_type  status,
   input  wire logic [AW-1:0]           p_idx,
   output mle_pkg::ctl_cmd_type         cmd,
   output logic [AW-1:0]                rd_addr,
   output logic [AW-1:0]                wr_addr
);

   typedef enum logic [17:0] {
      ST_IDLE     = 18'h00001,
      ST_START_WR = 18'h00002,
      ST_SCAN     = 18'h00004,
      ST_DRAIN1   = 18'h00008,
      ST_DRAIN2   = 18'h00010,
      ST_EVAL     = 18'h00020,
      ST_LO_CHK   = 18'h00040,
      ST_HI_CHK   = 18'h00080,
      ST_T_A      = 18'h00100,
      ST_T_B      = 18'h00200,
      ST_T_C      = 18'h00400,
      ST_T_GO     = 18'h00800,
      ST_T_WAIT   = 18'h01000,
      ST_SIZE     = 18'h02000,
      ST_CP_RD    = 18'h04000,
      ST_CP_WR    = 18'h08000,
      ST_WR_NEW   = 18'h10000,
      ST_FIN      = 18'h20000
   } state_type;

   typedef enum logic [1:0] {
      KIND_T0,   // new line between its neighbours
      KIND_LO,   // line below the new one
      KIND_HI    // line above the new one
   } kind_type;

   state_type      state_ff, state_in;
   kind_type       kind_ff, kind_in;
   logic [IW-1:0]  n_ff, n_in, i_ff, i_in, d_ff, d_in;
   logic [IW-1:0]  p_ff, p_in, rs_ff, rs_in, lo_ff, lo_in, hi_ff, hi_in;
   logic           full_ff, full_in, desc_ff, desc_in, rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0]  p_sel, rs_sel, addr_a, addr_b, addr_c;
   logic           new_a, new_b, new_c, is_start;
   logic [IW:0]    newn;

   always_comb begin
      addr_a = p_ff - IW'(1);
      addr_b = '0;
      addr_c = rs_ff;
      new_a  = 1'b0;
      new_b  = 1'b1;
      new_c  = 1'b0;
      case (kind_ff)
         KIND_T0: begin
            addr_a = p_ff - IW'(1);
            addr_b = '0;
            addr_c = rs_ff;
            new_a  = 1'b0;
            new_b  = 1'b1;
            new_c  = 1'b0;
         end
         KIND_LO: begin
            addr_a = lo_ff - IW'(2);
            addr_b = lo_ff - IW'(1);
            addr_c = '0;
            new_a  = 1'b0;
            new_b  = 1'b0;
            new_c  = 1'b1;
         end
         KIND_HI: begin
            addr_a = '0;
            addr_b = hi_ff;
            addr_c = hi_ff + IW'(1);
            new_a  = 1'b1;
            new_b  = 1'b0;
            new_c  = 1'b0;
         end
         default: ;
      endcase
   end

   always_comb begin
      is_start = req_start_req | (n_ff == '0);
      p_sel    = status.found ? IW'(p_idx) : n_ff;
      rs_sel   = p_sel + IW'(status.found & status.eq);
      newn     = {1'b0, lo_ff} + (IW+1)'(1) + {1'b0, n_ff} - {1'b0, hi_ff};
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      rs_in        = rs_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      full_in      = full_ff;
      desc_in      = desc_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      rd_addr      = '0;
      wr_addr      = '0;
      req_stall    = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept    = 1'b1;
               cmd.cost_zero = is_start;
               full_in       = 1'b0;
               i_in          = '0;
               state_in      = is_start ? ST_START_WR : ST_SCAN;
            end
         end
         ST_START_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_new = 1'b1;
            wr_addr    = '0;
            n_in       = IW'(1);
            state_in   = ST_FIN;
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            cmd.scan  = 1'b1;
            rd_addr   = i_ff[AW-1:0];
            if (i_ff == n_ff - IW'(1))
               state_in = ST_DRAIN1;
            else
               i_in = i_ff + IW'(1);
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_EVAL;
         ST_EVAL: begin
            p_in  = p_sel;
            rs_in = rs_sel;
            lo_in = p_sel;
            hi_in = rs_sel;
            // equal slope with no lower intercept: drop the new line
            if (status.found && status.eq && status.eq_le)
               state_in = ST_FIN;
            else if ((p_sel != '0) && (rs_sel < n_ff)) begin
               kind_in  = KIND_T0;
               state_in = ST_T_A;
            end else
               state_in = ST_LO_CHK;
         end
         ST_LO_CHK: begin
            if (lo_ff >= IW'(2)) begin
               kind_in  = KIND_LO;
               state_in = ST_T_A;
            end else
               state_in = ST_HI_CHK;
         end
         ST_HI_CHK: begin
            if (({1'b0, hi_ff} + (IW+1)'(1)) < {1'b0, n_ff}) begin
               kind_in  = KIND_HI;
               state_in = ST_T_A;
            end else
               state_in = ST_SIZE;
         end
         ST_T_A: begin
            cmd.rd_en = ~new_a;
            rd_addr   = addr_a[AW-1:0];
            state_in  = ST_T_B;
         end
         ST_T_B: begin
            cmd.ld_a      = 1'b1;
            cmd.src_a_new = new_a;
            cmd.rd_en     = ~new_b;
            rd_addr       = addr_b[AW-1:0];
            state_in      = ST_T_C;
         end
         ST_T_C: begin
            cmd.ld_b      = 1'b1;
            cmd.src_b_new = new_b;
            cmd.rd_en     = ~new_c;
            rd_addr       = addr_c[AW-1:0];
            state_in      = ST_T_GO;
         end
         ST_T_GO: begin
            cmd.ld_c      = 1'b1;
            cmd.src_c_new = new_c;
            cmd.mu_start  = 1'b1;
            state_in      = ST_T_WAIT;
         end
         ST_T_WAIT: begin
            if (status.mu_done) begin
               case (kind_ff)
                  KIND_T0: state_in = status.mu_useless ? ST_FIN : ST_LO_CHK;
                  KIND_LO: begin
                     if (status.mu_useless) begin
                        lo_in    = lo_ff - IW'(1);
                        state_in = ST_LO_CHK;
                     end else
                        state_in = ST_HI_CHK;
                  end
                  KIND_HI: begin
                     if (status.mu_useless) begin
                        hi_in    = hi_ff + IW'(1);
                        state_in = ST_HI_CHK;
                     end else
                        state_in = ST_SIZE;
                  end
                  default: state_in = ST_FIN;
               endcase
            end
         end
         ST_SIZE: begin
            if (newn > (IW+1)'(MAX_LINES)) begin
               full_in  = 1'b1;
               state_in = ST_FIN;
            end else if (hi_ff < n_ff) begin
               // close the gap upwards, or open one slot downwards
               if ((lo_ff + IW'(1)) <= hi_ff) begin
                  desc_in = 1'b0;
                  i_in    = hi_ff;
                  d_in    = lo_ff + IW'(1);
               end else begin
                  desc_in = 1'b1;
                  i_in    = n_ff - IW'(1);
                  d_in    = n_ff;
               end
               state_in = ST_CP_RD;
            end else
               state_in = ST_WR_NEW;
         end
         ST_CP_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = i_ff[AW-1:0];
            state_in  = ST_CP_WR;
         end
         ST_CP_WR: begin
            cmd.wr_en = 1'b1;
            wr_addr   = d_ff[AW-1:0];
            if (desc_ff) begin
               if (i_ff == hi_ff)
                  state_in = ST_WR_NEW;
               else begin
                  i_in     = i_ff - IW'(1);
                  d_in     = d_ff - IW'(1);
                  state_in = ST_CP_RD;
               end
            end else begin
               if (i_ff == n_ff - IW'(1))
                  state_in = ST_WR_NEW;
               else begin
                  i_in     = i_ff + IW'(1);
                  d_in     = d_ff + IW'(1);
                  state_in = ST_CP_RD;
               end
            end
         end
         ST_WR_NEW: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_new = 1'b1;
            wr_addr    = lo_ff[AW-1:0];
            n_in       = newn[IW-1:0];
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               cmd.out_full = full_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
         full_ff      <= full_in;
      end
      kind_ff <= kind_in;
      i_ff    <= i_in;
      d_ff    <= d_in;
      p_ff    <= p_in;
      rs_ff   <= rs_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      desc_ff <= desc_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ rtl/core/min_line_envelope_dp.sv @@
// Top level of the line-envelope DP block: joins mle_ctrl and mle_dp.
// Uses mle_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One item is worked at a time. A start item (or any item on an empty store)
// writes its line and hands over its result. Any other item first scans the
// n stored lines for the minimum (one store read per line, then drain states
// for the product pipeline and an evaluate state). Each envelope test reads
// two stored lines, takes the new line from its register and launches the
// middle-line unit, which steps through a difference, four products and a
// compare on a single 32x32 multiplier, then flags its answer. The lower,
// upper and size checks are states of their own. Every stored line above the
// insertion point moves, with one store read and one write a line; then the
// line is written and the result handed over (only the hand-over when the
// line is dropped or the store is full). An equal-slope line that is not
// lower ends straight after the scan. The single read port of the line store
// sets the scan and move cost. A finished result sits in an output register,
// so the next item is taken while it waits; req_stall is high while busy.
module min_line_envelope_dp #(
   parameter int MAX_LINES = mle_pkg::MAX_LINES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_start_req,
   input  wire logic [mle_pkg::SLOPE_W-1:0]   req_slope,
   input  wire logic [mle_pkg::X_W-1:0]       req_query_x,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [mle_pkg::COST_W-1:0]         rsp_cost,
   output logic                               rsp_store_full
);

   localparam int AW = $clog2(MAX_LINES);
   localparam int IW = $clog2(MAX_LINES + 1);

   mle_pkg::ctl_cmd_type   cmd;
   mle_pkg::dp_status_type status;
   logic [AW-1:0]          rd_addr, wr_addr, p_idx;

   mle_ctrl #(
      .MAX_LINES (MAX_LINES),
      .AW        (AW),
      .IW        (IW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_start_req (req_start_req),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .p_idx         (p_idx),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr)
   );

   mle_dp #(
      .MAX_LINES (MAX_LINES),
      .AW        (AW)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_slope      (req_slope),
      .req_query_x    (req_query_x),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .wr_addr        (wr_addr),
      .status         (status),
      .p_idx          (p_idx),
      .rsp_cost       (rsp_cost),
      .rsp_store_full (rsp_store_full)
   );

endmodule
`default_nettype wire
